[hdl/stepper_phase_sequencer_core_defines.svh]
// Assertion macros for the checker file of the stepper phase sequencer.
// No dependencies; include guard below.
`ifndef STEPPER_PHASE_SEQUENCER_CORE_DEFINES_SVH
`define STEPPER_PHASE_SEQUENCER_CORE_DEFINES_SVH

// Clocked assertion, switched off while reset is held
`define PSQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define PSQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/psq_pkg.sv]
// Package for the stepper phase sequencer: item structs, opcodes, state record
// and the coil pattern lookup. No dependencies.
package psq_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_OFF   = 2'd2;

    localparam int GROUPS_W = 17;
    localparam int ANGLE_W  = 16;

    // floor(angle*64/45) == (angle * RECIP_45) >> RECIP_SHIFT for every 16-bit angle
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_45 = 23'd5965233;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        step_mode;
        logic        direction;
        logic [7:0]  phase_delay_ms;
        logic [15:0] angle_degrees;
    } cmd_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy_res;
        logic       move_done;
        logic       rejected;
    } res_t;

    typedef struct packed {
        logic [3:0]          coil_state;
        logic                moving;
        logic [2:0]          phase_index;
        logic [GROUPS_W-1:0] groups_left;
        logic [7:0]          hold_countdown;
        logic [7:0]          hold_length;
        logic                half_mode;
        logic                reverse_dir;
    } seq_state_t;

    localparam logic [3:0] HALF_PATTERN [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                                4'h4, 4'hC, 4'h8, 4'h9};

    function automatic logic [3:0] pattern_for(input logic half, input logic rev,
                                               input logic [2:0] idx);
        logic [2:0] i;
        logic [1:0] j;
        i = rev ? ~idx : idx;
        j = rev ? ~idx[1:0] : idx[1:0];
        if (half)
            return HALF_PATTERN[i];
        else
            return 4'b0001 << j;
    endfunction

endpackage

[hdl/psq_group_calc.sv]
// Group count of a move: floor(angle*64/45), which equals both the full-step
// and the half-step formulas. Uses psq_pkg.
module psq_group_calc (
    input  logic [psq_pkg::ANGLE_W-1:0]  angle,
    output logic [psq_pkg::GROUPS_W-1:0] groups
);

    logic [psq_pkg::ANGLE_W+psq_pkg::RECIP_W-1:0] product;

    // reciprocal error is small enough that no correction step is needed
    assign product = {{psq_pkg::RECIP_W{1'b0}}, angle} *
                     {{psq_pkg::ANGLE_W{1'b0}}, psq_pkg::RECIP_45};
    assign groups  = product[psq_pkg::RECIP_SHIFT +: psq_pkg::GROUPS_W];

endmodule

[hdl/psq_next_state.sv]
// Per-item update of the sequencer state and the result item.
// Uses psq_pkg; group count comes from psq_group_calc.
module psq_next_state (
    input  psq_pkg::seq_state_t          state,
    input  psq_pkg::cmd_t                cmd,
    input  logic [psq_pkg::GROUPS_W-1:0] groups,
    output psq_pkg::seq_state_t          state_next,
    output psq_pkg::res_t                result
);

    always_comb
    begin
        logic       done;
        logic       rej;
        logic [7:0] hold;
        logic [2:0] last;
        logic [psq_pkg::GROUPS_W-1:0] left_dec;

        done       = 1'b0;
        rej        = 1'b0;
        state_next = state;
        hold       = (cmd.phase_delay_ms == 8'd0) ? 8'd1 : cmd.phase_delay_ms;
        last       = state.half_mode ? 3'd7 : 3'd3;
        left_dec   = state.groups_left - {{(psq_pkg::GROUPS_W-1){1'b0}}, 1'b1};

        unique case (cmd.opcode)
            psq_pkg::OP_START:
            begin
                if (state.moving)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    state_next.half_mode   = cmd.step_mode;
                    state_next.reverse_dir = cmd.direction;
                    state_next.hold_length = hold;
                    state_next.phase_index = 3'd0;
                    if (groups == '0)
                    begin
                        // zero-length move: coils untouched
                        state_next.groups_left    = '0;
                        state_next.hold_countdown = 8'd0;
                        done                      = 1'b1;
                    end
                    else
                    begin
                        state_next.groups_left    = groups;
                        state_next.moving         = 1'b1;
                        state_next.hold_countdown = hold;
                        state_next.coil_state     = psq_pkg::pattern_for(cmd.step_mode,
                                                        cmd.direction, 3'd0);
                    end
                end
            end
            psq_pkg::OP_TICK:
            begin
                if (state.moving)
                begin
                    if (state.hold_countdown > 8'd1)
                    begin
                        state_next.hold_countdown = state.hold_countdown - 8'd1;
                    end
                    else if (state.phase_index >= last)
                    begin
                        state_next.groups_left = left_dec;
                        state_next.phase_index = 3'd0;
                        if (left_dec == '0)
                        begin
                            state_next.moving         = 1'b0;
                            state_next.hold_countdown = 8'd0;
                            done                      = 1'b1;
                        end
                        else
                        begin
                            state_next.coil_state     = psq_pkg::pattern_for(state.half_mode,
                                                            state.reverse_dir, 3'd0);
                            state_next.hold_countdown = state.hold_length;
                        end
                    end
                    else
                    begin
                        state_next.phase_index    = state.phase_index + 3'd1;
                        state_next.coil_state     = psq_pkg::pattern_for(state.half_mode,
                                                        state.reverse_dir,
                                                        state.phase_index + 3'd1);
                        state_next.hold_countdown = state.hold_length;
                    end
                end
            end
            psq_pkg::OP_OFF:
            begin
                state_next.coil_state     = 4'd0;
                state_next.moving         = 1'b0;
                state_next.phase_index    = 3'd0;
                state_next.groups_left    = '0;
                state_next.hold_countdown = 8'd0;
            end
            default:
            begin
                // unused opcode: no change
            end
        endcase

        result.coils     = state_next.coil_state;
        result.busy_res  = state_next.moving;
        result.move_done = done;
        result.rejected  = rej;
    end

endmodule

[hdl/stepper_phase_sequencer_core.sv]
// Stepper phase sequencer, top level.
// An accepted item waits in the input register; its result goes to the output register.
// Throughput: one item per cycle unless res_ready stalls the output; an empty input
// register still takes an item while a result waits in the output register.
// Reset (rst_n low, asynchronous): coils off, no move, both registers empty.
// Uses psq_pkg, psq_group_calc, psq_next_state.
module stepper_phase_sequencer_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  psq_pkg::cmd_t  cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output psq_pkg::res_t  res
);

    logic                          cmd_valid_reg;
    psq_pkg::cmd_t                 cmd_reg;
    logic                          res_valid_reg;
    psq_pkg::res_t                 res_reg;
    psq_pkg::seq_state_t           state_reg;
    psq_pkg::seq_state_t           state_next;
    psq_pkg::res_t                 res_next;
    logic [psq_pkg::GROUPS_W-1:0]  groups;
    logic                          advance;

    assign advance   = !res_valid_reg || res_ready;
    assign cmd_ready = !cmd_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    psq_group_calc u_group_calc (
        .angle  (cmd_reg.angle_degrees),
        .groups (groups)
    );

    psq_next_state u_next_state (
        .state      (state_reg),
        .cmd        (cmd_reg),
        .groups     (groups),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cmd_ready)
                cmd_valid_reg <= cmd_valid;
            if (advance)
                res_valid_reg <= cmd_valid_reg;
            // state moves on only when the item leaves the input register
            if (advance && cmd_valid_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            cmd_reg <= cmd;
        if (advance && cmd_valid_reg)
            res_reg <= res_next;
    end

endmodule

[hdl/psq_checker.sv]
// Port-level checks for the stepper phase sequencer, bound to the top level.
// Uses psq_pkg and the macros in stepper_phase_sequencer_core_defines.svh.
`include "stepper_phase_sequencer_core_defines.svh"

module psq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          res_valid,
    input logic          res_ready,
    input psq_pkg::res_t res
);

    `PSQ_ASSERT(a_res_hold, clk, rst_n,
        res_valid && !res_ready |=> res_valid && $stable(res),
        "result item changed while stalled")
    `PSQ_ASSERT(a_done_idle, clk, rst_n,
        res_valid && res.move_done |-> !res.busy_res && !res.rejected,
        "move_done with busy or rejected")
    `PSQ_ASSERT(a_reject_busy, clk, rst_n,
        res_valid && res.rejected |-> res.busy_res,
        "start rejected while idle")
    `PSQ_ASSERT(a_busy_coil, clk, rst_n,
        res_valid && res.busy_res |-> res.coils != 4'd0,
        "moving with no coil energised")
    `PSQ_ASSERT_ALWAYS(a_reset_empty, clk,
        !rst_n |=> !res_valid,
        "result valid straight after reset")

endmodule

bind stepper_phase_sequencer_core psq_checker u_psq_checker (.*);

[sim/testbench.sv]
// Self-checking testbench for stepper_phase_sequencer_core: directed and random
// command items are checked against an in-bench model of the coil sequencer.
// Depends on psq_pkg and the RTL of stepper_phase_sequencer_core.
module testbench;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [3:0] FULL_WAVE_CW [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [3:0] HALF_STEP_CW [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                                4'h4, 4'hC, 4'h8, 4'h9};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    psq_pkg::cmd_t cmd = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    psq_pkg::res_t res;

    // model state of the sequencer
    logic [3:0]  mdl_coils;
    logic        mdl_moving;
    logic [2:0]  mdl_phase;
    logic [16:0] mdl_groups;
    logic [7:0]  mdl_hold_cnt;
    logic [7:0]  mdl_hold_len;
    logic        mdl_half;
    logic        mdl_rev;

    psq_pkg::res_t coil_results_due [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_left = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int moves_done = 0;
    int starts_refused = 0;

    stepper_phase_sequencer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [3:0] coil_pattern(input logic [2:0] idx);
        logic [2:0] i;
        logic [1:0] j;
        i = mdl_rev ? 3'd7 - idx : idx;
        j = mdl_rev ? 2'd3 - idx[1:0] : idx[1:0];
        return mdl_half ? HALF_STEP_CW[i] : FULL_WAVE_CW[j];
    endfunction

    // Advances the model by one command item and returns the expected result.
    function automatic psq_pkg::res_t step_coil_model(input psq_pkg::cmd_t c);
        psq_pkg::res_t r;
        int unsigned ang;
        int unsigned groups;
        logic [2:0] last_phase;
        r = '0;
        ang = c.angle_degrees;
        case (c.opcode)
            psq_pkg::OP_START:
            begin
                if (mdl_moving)
                    r.rejected = 1'b1;
                else
                begin
                    if (c.step_mode)
                        groups = ((ang * 512) / 45) / 8;
                    else
                        groups = ((ang * 256) / 45) / 4;
                    mdl_half = c.step_mode;
                    mdl_rev = c.direction;
                    mdl_hold_len = (c.phase_delay_ms == 8'd0) ? 8'd1 : c.phase_delay_ms;
                    mdl_phase = 3'd0;
                    if (groups == 0)
                    begin
                        // zero-length move: coils untouched, done at once
                        mdl_groups = '0;
                        mdl_hold_cnt = 8'd0;
                        r.move_done = 1'b1;
                    end
                    else
                    begin
                        mdl_groups = groups[16:0];
                        mdl_moving = 1'b1;
                        mdl_hold_cnt = mdl_hold_len;
                        mdl_coils = coil_pattern(3'd0);
                    end
                end
            end
            psq_pkg::OP_TICK:
            begin
                if (mdl_moving)
                begin
                    if (mdl_hold_cnt > 8'd1)
                        mdl_hold_cnt = mdl_hold_cnt - 8'd1;
                    else
                    begin
                        last_phase = mdl_half ? 3'd7 : 3'd3;
                        if (mdl_phase >= last_phase)
                        begin
                            mdl_groups = mdl_groups - 17'd1;
                            mdl_phase = 3'd0;
                            if (mdl_groups == '0)
                            begin
                                mdl_moving = 1'b0;
                                mdl_hold_cnt = 8'd0;
                                r.move_done = 1'b1;
                            end
                            else
                            begin
                                mdl_coils = coil_pattern(3'd0);
                                mdl_hold_cnt = mdl_hold_len;
                            end
                        end
                        else
                        begin
                            mdl_phase = mdl_phase + 3'd1;
                            mdl_coils = coil_pattern(mdl_phase);
                            mdl_hold_cnt = mdl_hold_len;
                        end
                    end
                end
            end
            psq_pkg::OP_OFF:
            begin
                mdl_coils = 4'h0;
                mdl_moving = 1'b0;
                mdl_phase = 3'd0;
                mdl_groups = '0;
                mdl_hold_cnt = 8'd0;
            end
            default:
            begin
            end
        endcase
        r.coils = mdl_coils;
        r.busy_res = mdl_moving;
        return r;
    endfunction

    function automatic psq_pkg::cmd_t make_cmd(input logic [1:0] op, input logic mode,
                                               input logic dir, input logic [7:0] delay,
                                               input logic [15:0] angle);
        psq_pkg::cmd_t c;
        c.opcode = op;
        c.step_mode = mode;
        c.direction = dir;
        c.phase_delay_ms = delay;
        c.angle_degrees = angle;
        return c;
    endfunction

    function automatic psq_pkg::cmd_t rand_cmd(input logic [1:0] op);
        return make_cmd(op, 1'($urandom), 1'($urandom), 8'($urandom), 16'($urandom));
    endfunction

    task automatic send_cmd(input psq_pkg::cmd_t c);
        psq_pkg::res_t want;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        want = step_coil_model(c);
        coil_results_due.push_back(want);
        items_sent++;
        if (want.move_done)
            moves_done++;
        if (want.rejected)
            starts_refused++;
    endtask

    // Sender stays quiet until every outstanding result item is back.
    task automatic wait_all_results();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (coil_results_due.size() != 0);
    endtask

    task automatic test_directed_cases();
        // tick while idle
        send_cmd(make_cmd(psq_pkg::OP_TICK, 1'b0, 1'b0, 8'd0, 16'd0));
        // unused opcode
        send_cmd(make_cmd(OP_UNUSED, 1'b1, 1'b1, 8'hFF, 16'hFFFF));
        // zero-length move
        send_cmd(make_cmd(psq_pkg::OP_START, 1'b0, 1'b0, 8'd0, 16'd0));
        // full step clockwise, hold 0 taken as 1, one group
        send_cmd(make_cmd(psq_pkg::OP_START, 1'b0, 1'b0, 8'd0, 16'd1));
        // refused, busy
        send_cmd(make_cmd(psq_pkg::OP_START, 1'b1, 1'b1, 8'd7, 16'd90));
        repeat (4)
            send_cmd(make_cmd(psq_pkg::OP_TICK, 1'b0, 1'b0, 8'd0, 16'd0));
        // zero-length after a move leaves the last pattern on
        send_cmd(make_cmd(psq_pkg::OP_START, 1'b1, 1'b0, 8'd3, 16'd0));
        send_cmd(make_cmd(psq_pkg::OP_START, 1'b0, 1'b1, 8'd2, 16'd1));
        send_cmd(make_cmd(psq_pkg::OP_TICK, 1'b1, 1'b1, 8'hFF, 16'hFFFF));
        send_cmd(make_cmd(psq_pkg::OP_TICK, 1'b0, 1'b0, 8'd0, 16'd0));
        send_cmd(make_cmd(psq_pkg::OP_OFF, 1'b0, 1'b0, 8'd0, 16'd0));
        send_cmd(make_cmd(psq_pkg::OP_START, 1'b1, 1'b1, 8'd1, 16'd1));
        repeat (3)
            send_cmd(make_cmd(psq_pkg::OP_TICK, 1'b0, 1'b0, 8'd0, 16'd0));
        send_cmd(make_cmd(psq_pkg::OP_OFF, 1'b1, 1'b1, 8'hFF, 16'hFFFF));
        // largest half-step move, longest hold, aborted
        send_cmd(make_cmd(psq_pkg::OP_START, 1'b1, 1'b0, 8'hFF, 16'hFFFF));
        send_cmd(make_cmd(psq_pkg::OP_TICK, 1'b0, 1'b0, 8'd0, 16'd0));
        send_cmd(make_cmd(psq_pkg::OP_OFF, 1'b0, 1'b0, 8'd0, 16'd0));
        wait_all_results();
    endtask

    // Mostly short complete moves with random content; some huge or aborted,
    // with stray starts, offs and unused opcodes mixed in.
    task automatic test_random_moves(input int n_items);
        psq_pkg::cmd_t c;
        int sent_here;
        int ticks;
        int roll;
        sent_here = 0;
        while (sent_here < n_items)
        begin
            c = rand_cmd(psq_pkg::OP_START);
            if ($urandom_range(99) < 85)
            begin
                c.angle_degrees = 16'($urandom_range(0, 2));
                c.phase_delay_ms = 8'($urandom_range(0, 3));
            end
            send_cmd(c);
            sent_here++;
            ticks = 0;
            while (mdl_moving && sent_here < n_items)
            begin
                roll = $urandom_range(99);
                if (ticks >= 150 || roll < 2)
                    c = rand_cmd(psq_pkg::OP_OFF);
                else if (roll < 5)
                    c = rand_cmd(psq_pkg::OP_START);
                else if (roll < 7)
                    c = rand_cmd(OP_UNUSED);
                else
                    c = rand_cmd(psq_pkg::OP_TICK);
                send_cmd(c);
                sent_here++;
                ticks++;
            end
            repeat ($urandom_range(0, 2))
            begin
                c = rand_cmd($urandom_range(1) ? psq_pkg::OP_TICK : OP_UNUSED);
                send_cmd(c);
                sent_here++;
            end
        end
    endtask

    task automatic test_output_backpressure();
        rx_hold_left = 400;
        test_random_moves(60);
        wait_all_results();
    endtask

    task automatic test_idle_mix(input int tx_pct, input int rx_pct, input int n_items);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        test_random_moves(n_items);
        wait_all_results();
    endtask

    // Receiver: checks each accepted result item and decides next ready.
    always @(posedge clk)
    begin : result_monitor
        psq_pkg::res_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (coil_results_due.size() == 0)
                begin
                    $error("result item with none expected: coils %h", res.coils);
                    mismatches++;
                end
                else
                begin
                    want = coil_results_due.pop_front();
                    if (res.coils !== want.coils)
                    begin
                        $error("coils: expected %h, got %h", want.coils, res.coils);
                        mismatches++;
                    end
                    if (res.busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %b, got %b", want.busy_res, res.busy_res);
                        mismatches++;
                    end
                    if (res.move_done !== want.move_done)
                    begin
                        $error("move_done: expected %b, got %b", want.move_done, res.move_done);
                        mismatches++;
                    end
                    if (res.rejected !== want.rejected)
                    begin
                        $error("rejected: expected %b, got %b", want.rejected, res.rejected);
                        mismatches++;
                    end
                end
            end
            if (rx_hold_left > 0)
            begin
                res_ready <= 1'b0;
                rx_hold_left--;
            end
            else
                res_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        mdl_coils = 4'h0;
        mdl_moving = 1'b0;
        mdl_phase = 3'd0;
        mdl_groups = '0;
        mdl_hold_cnt = 8'd0;
        mdl_hold_len = 8'd0;
        mdl_half = 1'b0;
        mdl_rev = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 26;
        rx_idle_pct = 47;
        test_directed_cases();
        test_idle_mix(26, 47, 560);
        test_output_backpressure();
        test_idle_mix(47, 26, 560);
        test_idle_mix(0, 0, 560);

        wait_all_results();
        repeat (8)
            @(posedge clk);

        $display("Run covered %0d command items and %0d checked results:", items_sent,
                 results_seen);
        $display("%0d moves completed, %0d starts refused while busy.", moves_done,
                 starts_refused);
        if (mismatches == 0 && coil_results_due.size() == 0)
            $display("stepper_phase_sequencer_core regression: pass");
        else
            $display("stepper_phase_sequencer_core regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("stepper_phase_sequencer_core regression: fail");
        $finish;
    end

endmodule
